// ===== sv/lpf_pkg.sv =====
// shared constants and types for the largest prime factor core
// no dependencies; imported by lpf_div and largest_prime_factor_core
`timescale 1ns / 1ps
`default_nettype none

package lpf_pkg;

  // width of the result word, fixed whatever the input width
  localparam int unsigned RES_WIDTH = 64;

  // status from the trial divider back to the sequencer
  typedef struct packed {
    logic done;        // one-cycle pulse, quotient and remainder valid
    logic rem_zero;    // divisor divides the dividend
    logic quo_lt_div;  // quotient below divisor, i.e. divisor squared exceeds dividend
  } lpf_div_stat_t;

endpackage

`default_nettype wire

// ===== sv/lpf_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on lpf_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module lpf_div #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [DATA_WIDTH-1:0]    dividend_i,
  input  wire logic [DATA_WIDTH-1:0]    divisor_i,
  output logic      [DATA_WIDTH-1:0]    quotient_o,
  output lpf_pkg::lpf_div_stat_t        stat_o
);
  import lpf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] rem_q;
  logic [DATA_WIDTH-1:0] quo_q;
  logic [DATA_WIDTH-1:0] dvs_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] trial;
  logic                  fits;

  // dividend bits leave quo_q at the top while quotient bits enter at the bottom
  assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~trial[DATA_WIDTH+1];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_q <= {quo_q[DATA_WIDTH-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DATA_WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

  assign quotient_o        = quo_q;
  assign stat_o.done       = done_q;
  assign stat_o.rem_zero   = (rem_q == '0);
  assign stat_o.quo_lt_div = (quo_q < dvs_q);

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == '0 && !start_i |=> done_q && !busy_q)
    else $error("divider missed its done pulse");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done raised while still dividing");

endmodule

`default_nettype wire

// ===== sv/largest_prime_factor_core.sv =====
// Largest prime factor core: trial division that divides out the smallest factor first.
//
// Input channel: in_valid_i / in_stall_o with number_i. One word is taken when valid
// is high and stall is low; stall stays high while a number is being factored.
// Output channel: out_valid_o / out_stall_i with largest_factor_o and invalid_o, held
// in an output register, so a new number is taken while a result waits there.
// A zero input gives factor 0 with invalid set; an input of one gives 1.
// Each trial division runs on the bit-serial divider.
// The number of trials is one per prime factor divided out, one per candidate passed,
// plus one to finish; candidates run up to the larger of the second largest prime
// factor and the square root of the largest. A power of two 2^k takes k + 1 trials;
// a prime near 2^64 takes about 2^31 trials. After the last trial the core passes
// through ST_FIN, which loads the output register; a zero input goes there from idle.
// When the receiver stalls the result is held stable, and a finished search waits
// in the core until the output register frees.
// Reset (rst_ni low, asynchronous) drops any number in flight and empties the output.
// Depends on lpf_pkg and lpf_div.
`timescale 1ns / 1ps
`default_nettype none

module largest_prime_factor_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [DATA_WIDTH-1:0]         number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [lpf_pkg::RES_WIDTH-1:0] largest_factor_o,
  output logic                               invalid_o
);
  import lpf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e                  state_q;
  logic [DATA_WIDTH-1:0]   n_q;
  logic [DATA_WIDTH-1:0]   p_q;
  logic [DATA_WIDTH-1:0]   best_q;
  logic                    inv_q;
  logic                    out_valid_q;
  logic [RES_WIDTH-1:0]    res_q;
  logic                    res_inv_q;

  logic                    div_start;
  logic [DATA_WIDTH-1:0]   div_dividend;
  logic [DATA_WIDTH-1:0]   div_divisor;
  logic [DATA_WIDTH-1:0]   div_quotient;
  lpf_div_stat_t           div_stat;
  logic [DATA_WIDTH-1:0]   p_next;
  logic                    out_free;

  lpf_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .stat_o     (div_stat)
  );

  // candidates run 2, 3, 5, 7, ...
  assign p_next   = (p_q == DATA_WIDTH'(2)) ? DATA_WIDTH'(3) : p_q + DATA_WIDTH'(2);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = number_i;
    div_divisor  = DATA_WIDTH'(2);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && number_i != '0) begin
          div_start = 1'b1;
        end
      end
      ST_RUN: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            // same candidate again on the reduced value
            div_start    = 1'b1;
            div_dividend = div_quotient;
            div_divisor  = p_q;
          end else if (!div_stat.quo_lt_div) begin
            div_start    = 1'b1;
            div_dividend = n_q;
            div_divisor  = p_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      p_q         <= '0;
      best_q      <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      res_inv_q   <= 1'b0;
    end else begin
      // a finishing search reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (number_i == '0) begin
              best_q  <= '0;
              inv_q   <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              n_q     <= number_i;
              p_q     <= DATA_WIDTH'(2);
              best_q  <= DATA_WIDTH'(1);
              inv_q   <= 1'b0;
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (div_stat.done) begin
            if (div_stat.rem_zero) begin
              n_q    <= div_quotient;
              best_q <= p_q;
            end else if (div_stat.quo_lt_div) begin
              // candidate squared exceeds what is left, so what is left is one or a prime
              if (n_q != DATA_WIDTH'(1)) begin
                best_q <= n_q;
              end
              state_q <= ST_FIN;
            end else begin
              p_q <= p_next;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            res_q       <= RES_WIDTH'(best_q);
            res_inv_q   <= inv_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign largest_factor_o = res_q;
  assign invalid_o        = res_inv_q;

  a_odd_candidate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (p_q == DATA_WIDTH'(2) || p_q[0]))
    else $error("even candidate above two");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_RUN)
    else $error("divider finished outside a search");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> largest_factor_o == '0)
    else $error("invalid word carries a factor");

  a_valid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_o |-> largest_factor_o != '0)
    else $error("valid word with zero factor");

endmodule

`default_nettype wire

// ===== tb/sv/lpf_checker.sv =====
// checker for the largest prime factor core: watches both channels and predicts each result
// depends on lpf_pkg for the result width; instantiated by tb_largest_prime_factor_core
`timescale 1ns / 1ps

module lpf_checker #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [DATA_WIDTH-1:0]         number_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [lpf_pkg::RES_WIDTH-1:0] largest_factor_i,
  input  logic                          invalid_i,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o,
  output int unsigned                   results_o
);

  typedef struct packed {
    logic [63:0]                  number;
    logic [lpf_pkg::RES_WIDTH-1:0] factor;
    logic                         invalid;
  } lpf_answer_t;

  lpf_answer_t factor_q[$];

  // strip factors of two, then odd trial divisors until the divisor squared passes the rest
  function automatic lpf_answer_t predict_factor(input logic [DATA_WIDTH-1:0] number);
    lpf_answer_t ans;
    logic [63:0] rest;
    logic [63:0] best;
    logic [63:0] p;
    rest = 64'(number);
    ans.number = rest;
    if (rest == 64'd0) begin
      ans.factor  = '0;
      ans.invalid = 1'b1;
      return ans;
    end
    best = 64'd1;
    while (rest[0] == 1'b0) begin
      best = 64'd2;
      rest = rest >> 1;
    end
    p = 64'd3;
    while (p <= rest / p) begin
      while (rest % p == 64'd0) begin
        best = p;
        rest = rest / p;
      end
      p = p + 64'd2;
    end
    // whatever is left is a prime above every factor removed so far
    if (rest > 64'd1) best = rest;
    ans.factor  = best;
    ans.invalid = 1'b0;
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lpf_answer_t exp_ans;
    if (!rst_ni) begin
      factor_q.delete();
      errors_o  <= 0;
      results_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (factor_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got factor %0d invalid %0b",
                   $time, largest_factor_i, invalid_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_ans = factor_q.pop_front();
          if (largest_factor_i !== exp_ans.factor || invalid_i !== exp_ans.invalid) begin
            errors_o <= errors_o + 1;
            if (largest_factor_i !== exp_ans.factor)
              $display("%0t: largest_factor for %0d: expected %0d, got %0d", $time,
                       exp_ans.number, exp_ans.factor, largest_factor_i);
            if (invalid_i !== exp_ans.invalid)
              $display("%0t: invalid for %0d: expected %0b, got %0b", $time,
                       exp_ans.number, exp_ans.invalid, invalid_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) factor_q.push_back(predict_factor(number_i));
      pending_o <= factor_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_largest_prime_factor_core.sv =====
// testbench top for largest_prime_factor_core: drives numbers and random output stalls
// depends on lpf_pkg, the core and lpf_checker, which predicts and compares every result
`timescale 1ns / 1ps

module tb_largest_prime_factor_core;

  localparam int unsigned DATA_WIDTH   = 64;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 8000000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [DATA_WIDTH-1:0]         number_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [lpf_pkg::RES_WIDTH-1:0] largest_factor_o;
  logic                          invalid_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b0;

  largest_prime_factor_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .number_i        (number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .largest_factor_o(largest_factor_o),
    .invalid_o       (invalid_o)
  );

  lpf_checker #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .number_i        (number_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .largest_factor_i(largest_factor_o),
    .invalid_i       (invalid_o),
    .errors_o        (errors),
    .pending_o       (pending),
    .results_o       (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls come in bursts, more often while a result is waiting
  initial begin
    int unsigned burst;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, out_valid_o ? 2 : 63) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_number(input logic [63:0] n);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= n[DATA_WIDTH-1:0];
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // smooth numbers keep the trial search short while still filling the high bits
  function automatic logic [63:0] random_number();
    logic [63:0] prod;
    logic [63:0] f;
    int unsigned bits;
    int unsigned tries;
    if ($urandom_range(0, 9) == 0) return 64'($urandom_range(0, 4095));
    bits = $urandom_range(1, 64);
    prod = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(2, 65535)) : 64'd1;
    for (tries = 0; tries < 200; tries++) begin
      f = 64'($urandom_range(2, 127));
      if (prod > 64'hFFFF_FFFF_FFFF_FFFF / f) break;
      if (bits < 64 && ((prod * f) >> bits) != 64'd0) break;
      prod = prod * f;
    end
    return prod;
  endfunction

  initial begin
    int unsigned k;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    number_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, one, primes, prime powers and words with the top bits set
    idle_on = 1'b1;
    push_number(64'd0);
    push_number(64'd1);
    push_number(64'd2);
    push_number(64'd3);
    push_number(64'd4);
    push_number(64'd6);
    push_number(64'd9409);
    push_number(64'd997);
    push_number(64'd65521);
    push_number(64'd999983);
    push_number(64'd1022117);
    idle_on = 1'b0;
    push_number(64'd0);
    push_number(64'd65521 << 32);
    push_number(64'h8000_0000_0000_0000);
    push_number(64'hFFFF_0000_0000_0000);
    push_number(64'hFF00_0000_0000_0000);
    push_number(64'd12157665459056928801);
    push_number(64'd3909821048582988049);
    push_number(64'd614889782588491410);
    push_number(64'd1);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      idle_on = (k < 35) || (k >= 50 && k < RANDOM_ITEMS - 20);
      push_number(random_number());
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d numbers: zero, one, primes, prime powers, smooth 64-bit words",
             items_sent);
    $display("%0d results checked in %0d cycles under random idling and stalls",
             results, cycle_count);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
